>>> design/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg: shared widths, constants and pipeline payload types
// Fixed-point sizing for the RGB to HSL converter and the structs that
// travel between its front end, divider pipeline and output stage.
// ----------------------------------------------------------------------------
package r2h_pkg;

    localparam int     CHANNEL_BITS  = 8;
    localparam int     HUE_FRAC_BITS = 4;

    localparam longint CHAN_FULL = (longint'(1) << CHANNEL_BITS) - 1;
    localparam longint HUE_STEP  = longint'(60) << HUE_FRAC_BITS;
    localparam longint HUE_TURN  = longint'(360) << HUE_FRAC_BITS;

    localparam int HUE_W  = $clog2(HUE_TURN);
    localparam int HQ_W   = $clog2(HUE_TURN + 1);
    localparam int SQ_W   = CHANNEL_BITS;
    localparam int DV_W   = CHANNEL_BITS + 1;
    localparam int SEC_W  = $clog2(6 * CHAN_FULL + 1);
    localparam int HR_W   = HQ_W + DV_W;
    localparam int SR_W   = SQ_W + DV_W;

    localparam int DIV_BITS   = (HQ_W > SQ_W) ? HQ_W : SQ_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    typedef struct packed {
        logic [SEC_W-1:0] sector;
        t_chan            diff;
        t_chan            den;
        t_chan            lum;
        t_chan            alpha;
        logic             grey;
    } t_prep;

    typedef struct packed {
        logic [HR_W-1:0] hue_rem;
        logic [DV_W-1:0] hue_div;
        logic [HQ_W-1:0] hue_quo;
        logic [SR_W-1:0] sat_rem;
        logic [DV_W-1:0] sat_div;
        logic [SQ_W-1:0] sat_quo;
        t_chan           lum;
        t_chan           alpha;
        logic            grey;
    } t_div;

endpackage

>>> design/r2h_prep.sv
// ----------------------------------------------------------------------------
// r2h_prep: front end, two register stages
// Find max, min, sector and saturation denominator, then form the
// dividend and divisor of both divisions.
// ----------------------------------------------------------------------------
module r2h_prep import r2h_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_chan i_red,
    input  t_chan i_green,
    input  t_chan i_blue,
    input  t_chan i_alpha,
    output logic  o_valid,
    input  logic  i_stall,
    output t_div  o_data
);

    t_chan            mx;
    t_chan            mn;
    t_chan            diff;
    logic [DV_W-1:0]  sum;
    logic [SEC_W-1:0] sector;
    t_prep            n_a;
    t_prep            r_a;
    t_div             n_b;
    t_div             r_b;
    logic             r_a_vld;
    logic             r_b_vld;
    logic             en_a;
    logic             en_b;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        diff = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};

        if (mx == i_red) begin
            if (i_green >= i_blue) begin
                sector = SEC_W'(i_green - i_blue);
            end else begin
                sector = SEC_W'(6 * diff) - SEC_W'(i_blue - i_green);
            end
        end else if (mx == i_green) begin
            sector = SEC_W'(2 * diff) + SEC_W'(i_blue) - SEC_W'(i_red);
        end else begin
            sector = SEC_W'(4 * diff) + SEC_W'(i_red) - SEC_W'(i_green);
        end

        n_a.sector = sector;
        n_a.diff   = diff;
        n_a.den    = (sum <= DV_W'(CHAN_FULL)) ? sum[CHANNEL_BITS-1:0]
                                               : t_chan'(DV_W'(2 * CHAN_FULL) - sum);
        n_a.lum    = sum[DV_W-1:1];
        n_a.alpha  = i_alpha;
        n_a.grey   = (diff == '0);
    end

    always_comb begin
        n_b.hue_rem = HR_W'(r_a.sector) * HR_W'(2 * HUE_STEP) + HR_W'(r_a.diff);
        n_b.hue_div = {r_a.diff, 1'b0};
        n_b.hue_quo = '0;
        n_b.sat_rem = SR_W'(r_a.diff) * SR_W'(2 * CHAN_FULL) + SR_W'(r_a.den);
        n_b.sat_div = {r_a.den, 1'b0};
        n_b.sat_quo = '0;
        n_b.lum     = r_a.lum;
        n_b.alpha   = r_a.alpha;
        n_b.grey    = r_a.grey;
    end

    assign en_b    = !r_b_vld || !i_stall;
    assign en_a    = !r_a_vld || en_b;
    assign o_stall = !en_a;
    assign o_valid = r_b_vld;
    assign o_data  = r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= i_valid;
            if (en_b) r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) r_a <= n_a;
        if (en_b) r_b <= n_b;
    end

endmodule

>>> design/r2h_div.sv
// ----------------------------------------------------------------------------
// r2h_div: pipelined restoring divider pair
// Each stage resolves up to two quotient bits of the hue and the saturation
// division; both run side by side in the same stages.
// ----------------------------------------------------------------------------
module r2h_div import r2h_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_div i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_div o_data
);

    t_div r_stg [DIV_STAGES];
    t_div n_stg [DIV_STAGES];
    t_div d_in  [DIV_STAGES];
    logic v_in  [DIV_STAGES];
    logic r_vld [DIV_STAGES];
    logic en    [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stage
            if (g == 0) begin : g_first
                assign d_in[g] = i_data;
                assign v_in[g] = i_valid;
            end else begin : g_next
                assign d_in[g] = r_stg[g-1];
                assign v_in[g] = r_vld[g-1];
            end

            if (g == DIV_STAGES - 1) begin : g_last
                assign en[g] = !r_vld[g] || !i_stall;
            end else begin : g_mid
                assign en[g] = !r_vld[g] || en[g+1];
            end

            always_comb begin
                t_div            x;
                logic [HR_W-1:0] hsh;
                logic [SR_W-1:0] ssh;
                x   = d_in[g];
                hsh = '0;
                ssh = '0;
                for (int j = 0; j < DIV_STEPS; j++) begin
                    if (g * DIV_STEPS + j < HQ_W) begin
                        hsh = HR_W'(x.hue_div) << (HQ_W - 1 - (g * DIV_STEPS + j));
                        if (x.hue_rem >= hsh) begin
                            x.hue_rem = x.hue_rem - hsh;
                            x.hue_quo = {x.hue_quo[HQ_W-2:0], 1'b1};
                        end else begin
                            x.hue_quo = {x.hue_quo[HQ_W-2:0], 1'b0};
                        end
                    end
                    if (g * DIV_STEPS + j < SQ_W) begin
                        ssh = SR_W'(x.sat_div) << (SQ_W - 1 - (g * DIV_STEPS + j));
                        if (x.sat_rem >= ssh) begin
                            x.sat_rem = x.sat_rem - ssh;
                            x.sat_quo = {x.sat_quo[SQ_W-2:0], 1'b1};
                        end else begin
                            x.sat_quo = {x.sat_quo[SQ_W-2:0], 1'b0};
                        end
                    end
                end
                n_stg[g] = x;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (en[g]) begin
                    r_vld[g] <= v_in[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[g]) r_stg[g] <= n_stg[g];
            end
        end
    endgenerate

    assign o_stall = !en[0];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_data  = r_stg[DIV_STAGES-1];

endmodule

>>> design/r2h_post.sv
// ----------------------------------------------------------------------------
// r2h_post: output stage
// Wrap a hue that rounded to a full turn, zero hue and saturation for a
// grey pixel, and hold the result in the output register.
// ----------------------------------------------------------------------------
module r2h_post import r2h_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_div             i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [HUE_W-1:0] o_hue,
    output t_chan            o_saturation,
    output t_chan            o_luminance,
    output t_chan            o_alpha_out
);

    logic [HQ_W-1:0]  hq;
    logic [HUE_W-1:0] n_hue;
    t_chan            n_sat;
    logic [HUE_W-1:0] r_hue;
    t_chan            r_sat;
    t_chan            r_lum;
    t_chan            r_alpha;
    logic             r_vld;
    logic             en;

    always_comb begin
        hq = i_data.hue_quo;
        if (hq >= HQ_W'(HUE_TURN)) hq = hq - HQ_W'(HUE_TURN);
        n_hue = i_data.grey ? '0 : hq[HUE_W-1:0];
        n_sat = i_data.grey ? '0 : i_data.sat_quo;
    end

    assign en      = !r_vld || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_lum   <= i_data.lum;
            r_alpha <= i_data.alpha;
        end
    end

    assign o_valid      = r_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_luminance  = r_lum;
    assign o_alpha_out  = r_alpha;

endmodule

>>> design/rgb_to_hsl_convert.sv
// Pipeline: 2 front-end stages, 7 divider stages, 1 output register; each
// divider stage resolves up to two quotient bits of the 13-bit hue quotient.
// Throughput: one pixel per cycle; a stall holds the full stages behind the
// output, while an empty stage still takes the item before it.
// Reset: synchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert: streaming RGB to HSL pixel converter
// Hue in sixteenths of a degree, rounded saturation, floor luminance,
// alpha passed along with the pixel.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert import r2h_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_chan            i_red,
    input  t_chan            i_green,
    input  t_chan            i_blue,
    input  t_chan            i_alpha,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [HUE_W-1:0] o_hue,
    output t_chan            o_saturation,
    output t_chan            o_luminance,
    output t_chan            o_alpha_out
);

    t_div prep_data;
    logic prep_valid;
    logic div_stall;
    t_div div_data;
    logic div_valid;
    logic post_stall;

    r2h_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_alpha (i_alpha),
        .o_valid (prep_valid),
        .i_stall (div_stall),
        .o_data  (prep_data)
    );

    r2h_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_stall (div_stall),
        .i_data  (prep_data),
        .o_valid (div_valid),
        .i_stall (post_stall),
        .o_data  (div_data)
    );

    r2h_post u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (div_valid),
        .o_stall      (post_stall),
        .i_data       (div_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_luminance  (o_luminance),
        .o_alpha_out  (o_alpha_out)
    );

endmodule

>>> design/r2h_check.sv
// ----------------------------------------------------------------------------
// r2h_check: port-level checker for the RGB to HSL converter
// Watches the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
module r2h_check import r2h_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input t_chan            i_red,
    input t_chan            i_green,
    input t_chan            i_blue,
    input t_chan            i_alpha,
    input logic             o_valid,
    input logic             i_stall,
    input logic [HUE_W-1:0] o_hue,
    input t_chan            o_saturation,
    input t_chan            o_luminance,
    input t_chan            o_alpha_out
);

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue < HUE_W'(HUE_TURN))
        else $error("hue out of range");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == '0 |-> o_hue == '0)
        else $error("zero saturation with nonzero hue");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while pipeline can advance");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue) && $stable(o_saturation)
            && $stable(o_luminance) && $stable(o_alpha_out))
        else $error("stalled result changed");

endmodule

bind rgb_to_hsl_convert r2h_check u_r2h_check (.*);

>>> sim/rgb_to_hsl_convert_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_tb: self-checking regression for the RGB to HSL converter
// Sends directed corner pixels and then about a thousand random pixels through
// the valid/stall input channel, with random gaps on both channels.
// Each result is checked field by field against a predictor that uses exact
// integer math. Expected results are matched in order.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_tb;
    import r2h_pkg::*;

    localparam int      RANDOM_PIXELS = 1030;
    localparam int      CYCLE_LIMIT   = 200000;
    localparam int      TAIL_CYCLES   = 20;
    localparam longint  FULL_SCALE    = (longint'(1) << CHANNEL_BITS) - 1;
    localparam longint  DEG_60        = longint'(60) << HUE_FRAC_BITS;
    localparam longint  DEG_360       = longint'(360) << HUE_FRAC_BITS;

    typedef struct {
        t_chan       red;
        t_chan       green;
        t_chan       blue;
        t_chan       alpha;
        int unsigned gap;
        bit          drain;
    } t_rgba_item;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        t_chan            sat;
        t_chan            lum;
        t_chan            alpha;
    } t_hsl;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_chan            i_red   = '0;
    t_chan            i_green = '0;
    t_chan            i_blue  = '0;
    t_chan            i_alpha = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [HUE_W-1:0] o_hue;
    t_chan            o_saturation;
    t_chan            o_luminance;
    t_chan            o_alpha_out;

    t_rgba_item  pixel_q[$];
    t_hsl        expected_hsl_q[$];
    t_rgba_item  next_px;
    t_hsl        want_hsl;
    int unsigned idle_cnt     = 0;
    int unsigned stall_left   = 0;
    int unsigned stall_draw;
    int unsigned result_cnt   = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;

    rgb_to_hsl_convert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_alpha      (i_alpha),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_luminance  (o_luminance),
        .o_alpha_out  (o_alpha_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_hsl predict_hsl(t_chan r, t_chan g, t_chan b, t_chan a);
        longint unsigned mx;
        longint unsigned mn;
        longint unsigned diff;
        longint unsigned sum;
        longint unsigned sector;
        longint unsigned den;
        longint unsigned hue;
        longint unsigned sat;
        t_hsl            res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        diff = mx - mn;
        sum  = mx + mn;
        hue  = 0;
        sat  = 0;
        if (diff != 0) begin
            if (mx == r) begin
                if (g >= b) sector = g - b;
                else        sector = 6 * diff + g - b;
            end else if (mx == g) begin
                sector = 2 * diff + b - r;
            end else begin
                sector = 4 * diff + r - g;
            end
            hue = (2 * DEG_60 * sector + diff) / (2 * diff);
            if (hue >= DEG_360) hue = hue - DEG_360;
            den = (sum <= FULL_SCALE) ? sum : 2 * FULL_SCALE - sum;
            if (den != 0) begin
                sat = (2 * FULL_SCALE * diff + den) / (2 * den);
                if (sat > FULL_SCALE) sat = FULL_SCALE;
            end else begin
                sat = FULL_SCALE;
            end
        end
        res.hue   = hue[HUE_W-1:0];
        res.sat   = sat[CHANNEL_BITS-1:0];
        res.lum   = sum[CHANNEL_BITS:1];
        res.alpha = a;
        return res;
    endfunction

    function automatic int unsigned draw_wait(int unsigned idx);
        case ((idx / 70) % 3)
            0: return 0;
            1: return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        endcase
    endfunction

    task automatic add_pixel(int unsigned r, int unsigned g, int unsigned b, int unsigned a,
                             int unsigned gap, bit drain);
        t_rgba_item px;
        px.red   = t_chan'(r);
        px.green = t_chan'(g);
        px.blue  = t_chan'(b);
        px.alpha = t_chan'(a);
        px.gap   = gap;
        px.drain = drain;
        pixel_q.push_back(px);
    endtask

    // driver: present the next pixel once its gap has passed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            idle_cnt <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_hsl_q.push_back(predict_hsl(i_red, i_green, i_blue, i_alpha));
            end
            if (!i_valid || !o_stall) begin
                if (pixel_q.size() != 0 && idle_cnt >= pixel_q[0].gap &&
                        (!pixel_q[0].drain || expected_hsl_q.size() == 0)) begin
                    next_px  = pixel_q.pop_front();
                    i_valid  <= 1'b1;
                    i_red    <= next_px.red;
                    i_green  <= next_px.green;
                    i_blue   <= next_px.blue;
                    i_alpha  <= next_px.alpha;
                    idle_cnt <= 0;
                end else begin
                    i_valid  <= 1'b0;
                    idle_cnt <= idle_cnt + 1;
                end
            end
        end
    end

    // monitor: check each result transfer and draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_hsl_q.size() == 0) begin
                    $display("%0t: unexpected result hue %0d sat %0d lum %0d alpha %0d",
                             $time, o_hue, o_saturation, o_luminance, o_alpha_out);
                    mismatch_cnt++;
                end else begin
                    want_hsl = expected_hsl_q.pop_front();
                    if (o_hue !== want_hsl.hue) begin
                        $display("%0t: hue expected %0d actual %0d",
                                 $time, want_hsl.hue, o_hue);
                        mismatch_cnt++;
                    end
                    if (o_saturation !== want_hsl.sat) begin
                        $display("%0t: saturation expected %0d actual %0d",
                                 $time, want_hsl.sat, o_saturation);
                        mismatch_cnt++;
                    end
                    if (o_luminance !== want_hsl.lum) begin
                        $display("%0t: luminance expected %0d actual %0d",
                                 $time, want_hsl.lum, o_luminance);
                        mismatch_cnt++;
                    end
                    if (o_alpha_out !== want_hsl.alpha) begin
                        $display("%0t: alpha expected %0d actual %0d",
                                 $time, want_hsl.alpha, o_alpha_out);
                        mismatch_cnt++;
                    end
                end
                result_cnt++;
                stall_draw = draw_wait(result_cnt + 35);
                i_stall    <= (stall_draw != 0);
                stall_left <= stall_draw;
            end else if (stall_left != 0) begin
                i_stall    <= (stall_left > 1);
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("rgb_to_hsl_convert regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned kind;
        int unsigned v;
        int unsigned w;
        int unsigned gap;

        // greys, pure primaries and secondaries, ties
        add_pixel(0, 0, 0, 0, 0, 0);
        add_pixel(255, 255, 255, 255, 0, 0);
        add_pixel(100, 100, 100, 8'hAA, 0, 0);
        add_pixel(255, 0, 0, 8'h55, 0, 0);
        add_pixel(0, 255, 0, 0, 0, 0);
        add_pixel(0, 0, 255, 255, 0, 0);
        add_pixel(255, 255, 0, 0, 0, 0);
        add_pixel(0, 255, 255, 0, 0, 0);
        add_pixel(255, 0, 255, 0, 3, 0);
        add_pixel(255, 0, 128, 0, 0, 0);
        // red maximum, green below blue: wrap close to a full turn
        add_pixel(255, 0, 1, 1, 0, 0);
        add_pixel(200, 10, 11, 2, 0, 0);
        add_pixel(10, 200, 10, 3, 0, 0);
        add_pixel(10, 10, 200, 4, 0, 0);
        // saturation cap and the dark/bright denominator boundary
        add_pixel(1, 0, 0, 5, 0, 0);
        add_pixel(0, 0, 1, 6, 0, 0);
        add_pixel(255, 254, 254, 7, 0, 0);
        add_pixel(254, 255, 255, 8, 0, 0);
        add_pixel(128, 127, 127, 9, 0, 0);
        add_pixel(127, 128, 128, 10, 0, 0);
        add_pixel(128, 128, 127, 11, 0, 0);
        add_pixel(128, 127, 128, 12, 0, 0);
        add_pixel(127, 0, 255, 13, 0, 0);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            kind = $urandom_range(0, 9);
            gap  = draw_wait(i);
            v    = $urandom_range(0, 255);
            w    = $urandom_range(0, 255);
            case (kind)
                5: add_pixel(v, v, v, $urandom_range(0, 255), gap, 0);
                6: add_pixel(v, (v == 255) ? 254 : v + 1, v, $urandom_range(0, 255), gap, 0);
                7: begin
                    case ($urandom_range(0, 2))
                        0: add_pixel(v, v, w, $urandom_range(0, 255), gap, 0);
                        1: add_pixel(v, w, v, $urandom_range(0, 255), gap, 0);
                        default: add_pixel(w, v, v, $urandom_range(0, 255), gap, 0);
                    endcase
                end
                8: add_pixel($urandom_range(0, 1) * 255, v, $urandom_range(0, 1) * 255,
                             $urandom_range(0, 255), gap, 0);
                9: begin
                    if ($urandom_range(0, 1) == 0)
                        add_pixel($urandom_range(0, 3), $urandom_range(0, 3),
                                  $urandom_range(0, 3), $urandom_range(0, 255), gap, 0);
                    else
                        add_pixel($urandom_range(252, 255), $urandom_range(252, 255),
                                  $urandom_range(252, 255), $urandom_range(0, 255), gap, 0);
                end
                default: add_pixel(v, w, $urandom_range(0, 255), $urandom_range(0, 255),
                                   gap, 0);
            endcase
            // hold the stream until the pipeline is empty
            if (i == 0 || i == RANDOM_PIXELS / 2) begin
                pixel_q[pixel_q.size() - 1].drain = 1'b1;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pixel_q.size() != 0 || i_valid || expected_hsl_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_hsl_q.size() == 0 && !i_valid) begin
            $display("rgb_to_hsl_convert regression: pass");
        end else begin
            $display("rgb_to_hsl_convert regression: fail");
        end
        $finish;
    end

endmodule
